[design/sm4_pkg.sv]
// SM4 package: word types, FSM states, register codes, S-box and key constants.
`timescale 1ns / 1ps
package sm4_pkg;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic        first_block;
    } t_in_word;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out_word;

    typedef enum logic [2:0] {
        S_KEY_INIT,
        S_KEY_RUN,
        S_IDLE,
        S_RUN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic       cfg_we;
        logic       key_init;
        logic       key_step;
        logic       blk_load;
        logic       rnd_step;
        logic       fin_load;
        logic [4:0] cnt;
        logic [4:0] rk_addr;
    } t_cmd;

    typedef struct packed {
        logic dec;
    } t_sts;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned ROUNDS    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IV_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHAINING  = 3'd5;

    localparam logic [63:0] IV_LOW_RESET = 64'h0102030405060708;

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    localparam logic [7:0] SBOX [0:255] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    // Byte-wise S-box substitution.
    function automatic logic [31:0] tau(input logic [31:0] x);
        return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

    // Key schedule constant CK(i): byte j is (4i + j) * 7 mod 256.
    function automatic logic [31:0] ck_word(input logic [4:0] i);
        logic [7:0]  s;
        logic [7:0]  b;
        logic [31:0] w;
        w = '0;
        for (int j = 0; j < 4; j++) begin
            s = {1'b0, i, 2'b00} + 8'(j);
            b = s * 8'd7;
            w = {w[23:0], b};
        end
        return w;
    endfunction

    // Linear transform of the data rounds.
    function automatic logic [31:0] lin_data(input logic [31:0] b);
        return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                 ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    endfunction

    // Linear transform of the key schedule.
    function automatic logic [31:0] lin_key(input logic [31:0] b);
        return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
    endfunction

endpackage

[design/sm4_ctrl.sv]
// SM4 controller: sequences key expansion, the 32 rounds and the result handoff.
`timescale 1ns / 1ps
module sm4_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sm4_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  sm4_pkg::t_sts                      i_sts,
    output sm4_pkg::t_cmd                      o_cmd
);

    sm4_pkg::t_state r_state, n_state;
    logic [4:0]      r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;
    logic            key_write;
    logic            in_accept;
    logic            fin_load;
    logic            last_step;

    assign key_write = i_cfg_valid && (r_state == sm4_pkg::S_IDLE) &&
                       ((i_cfg_index == sm4_pkg::REG_KEY_HIGH) ||
                        (i_cfg_index == sm4_pkg::REG_KEY_LOW));
    assign in_accept = i_in_valid && (r_state == sm4_pkg::S_IDLE) && !i_cfg_valid;
    assign fin_load  = (r_state == sm4_pkg::S_FIN) && (!r_out_valid || !i_out_stall);
    assign last_step = (r_cnt == 5'(sm4_pkg::ROUNDS - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sm4_pkg::S_KEY_INIT: n_state = sm4_pkg::S_KEY_RUN;
            sm4_pkg::S_KEY_RUN: begin
                if (last_step) n_state = sm4_pkg::S_IDLE;
            end
            sm4_pkg::S_IDLE: begin
                if (key_write)      n_state = sm4_pkg::S_KEY_INIT;
                else if (in_accept) n_state = sm4_pkg::S_RUN;
            end
            sm4_pkg::S_RUN: begin
                if (last_step) n_state = sm4_pkg::S_FIN;
            end
            sm4_pkg::S_FIN: begin
                if (fin_load) n_state = sm4_pkg::S_IDLE;
            end
            default: n_state = sm4_pkg::S_IDLE;
        endcase
    end

    // Outputs and commands.
    always_comb begin
        o_cmd          = '0;
        o_in_stall     = 1'b1;
        o_cfg_ready    = 1'b0;
        n_cnt          = '0;
        o_cmd.cnt      = r_cnt;
        o_cmd.rk_addr  = (r_cnt + 5'd1) ^ {5{i_sts.dec}};
        unique case (r_state)
            sm4_pkg::S_KEY_INIT: begin
                o_cmd.key_init = 1'b1;
            end
            sm4_pkg::S_KEY_RUN: begin
                o_cmd.key_step = 1'b1;
                n_cnt          = r_cnt + 5'd1;
            end
            sm4_pkg::S_IDLE: begin
                o_cfg_ready    = 1'b1;
                o_in_stall     = i_cfg_valid;
                o_cmd.cfg_we   = i_cfg_valid;
                o_cmd.blk_load = in_accept && !key_write;
                o_cmd.rk_addr  = {5{i_sts.dec}};
            end
            sm4_pkg::S_RUN: begin
                o_cmd.rnd_step = 1'b1;
                n_cnt          = r_cnt + 5'd1;
            end
            sm4_pkg::S_FIN: begin
                o_cmd.fin_load = fin_load;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign n_out_valid = fin_load || (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sm4_pkg::S_KEY_INIT;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[design/sm4_dpath.sv]
// SM4 datapath: config registers, round-key memory, shared round unit, chain and result.
`timescale 1ns / 1ps
module sm4_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sm4_pkg::t_cmd                 i_cmd,
    input  logic [sm4_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                   i_cfg_data,
    input  sm4_pkg::t_in_word             i_in_word,
    output sm4_pkg::t_out_word            o_out_word,
    output sm4_pkg::t_sts                 o_sts
);

    logic [63:0]  r_key_high, r_key_low, r_iv_high, r_iv_low;
    logic         r_dec, r_cbc;
    logic [127:0] r_chain, n_chain;
    logic [127:0] r_blk;
    logic [127:0] r_out;
    logic [31:0]  r_x [4];
    logic [31:0]  r_rk;
    logic [31:0]  rk_mem [sm4_pkg::ROUNDS];

    logic [127:0] blk_in;
    logic [127:0] chain_eff;
    logic [127:0] x_load;
    logic [127:0] cipher_out;
    logic [127:0] res;
    logic [31:0]  mix_in;
    logic [31:0]  sub_out;
    logic [31:0]  nx;

    assign o_sts.dec = r_dec;

    assign blk_in    = {i_in_word.block_high, i_in_word.block_low};
    assign chain_eff = i_in_word.first_block ? {r_iv_high, r_iv_low} : r_chain;
    assign x_load    = (r_cbc && !r_dec) ? (blk_in ^ chain_eff) : blk_in;

    // One round, shared by key expansion and data rounds.
    assign mix_in  = r_x[1] ^ r_x[2] ^ r_x[3] ^
                     (i_cmd.key_step ? sm4_pkg::ck_word(i_cmd.cnt) : r_rk);
    assign sub_out = sm4_pkg::tau(mix_in);
    assign nx      = r_x[0] ^ (i_cmd.key_step ? sm4_pkg::lin_key(sub_out)
                                              : sm4_pkg::lin_data(sub_out));

    assign cipher_out = {r_x[3], r_x[2], r_x[1], r_x[0]};
    assign res        = (r_cbc && r_dec) ? (cipher_out ^ r_chain) : cipher_out;

    always_comb begin
        n_chain = r_chain;
        if (i_cmd.blk_load) begin
            n_chain = chain_eff;
        end else if (i_cmd.fin_load && r_cbc) begin
            n_chain = r_dec ? r_blk : res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_iv_high  <= '0;
            r_iv_low   <= sm4_pkg::IV_LOW_RESET;
            r_dec      <= 1'b0;
            r_cbc      <= 1'b0;
            r_chain    <= '0;
        end else begin
            r_chain <= n_chain;
            if (i_cmd.cfg_we) begin
                unique case (i_cfg_index)
                    sm4_pkg::REG_KEY_HIGH:  r_key_high <= i_cfg_data;
                    sm4_pkg::REG_KEY_LOW:   r_key_low  <= i_cfg_data;
                    sm4_pkg::REG_IV_HIGH:   r_iv_high  <= i_cfg_data;
                    sm4_pkg::REG_IV_LOW:    r_iv_low   <= i_cfg_data;
                    sm4_pkg::REG_DIRECTION: r_dec      <= i_cfg_data[0];
                    sm4_pkg::REG_CHAINING:  r_cbc      <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Working state: key words during expansion, cipher words during rounds.
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_init) begin
            r_x[0] <= r_key_high[63:32] ^ sm4_pkg::FK0;
            r_x[1] <= r_key_high[31:0]  ^ sm4_pkg::FK1;
            r_x[2] <= r_key_low[63:32]  ^ sm4_pkg::FK2;
            r_x[3] <= r_key_low[31:0]   ^ sm4_pkg::FK3;
        end else if (i_cmd.blk_load) begin
            r_x[0] <= x_load[127:96];
            r_x[1] <= x_load[95:64];
            r_x[2] <= x_load[63:32];
            r_x[3] <= x_load[31:0];
        end else if (i_cmd.key_step || i_cmd.rnd_step) begin
            r_x[0] <= r_x[1];
            r_x[1] <= r_x[2];
            r_x[2] <= r_x[3];
            r_x[3] <= nx;
        end
        if (i_cmd.blk_load) r_blk <= blk_in;
        if (i_cmd.fin_load) r_out <= res;
    end

    // Round-key memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_step) rk_mem[i_cmd.cnt] <= nx;
        r_rk <= rk_mem[i_cmd.rk_addr];
    end

    assign o_out_word.result_high = r_out[127:64];
    assign o_out_word.result_low  = r_out[63:0];

endmodule

[design/sm4_block_cipher_ecb_cbc.sv]
// SM4 ECB/CBC cipher top level: controller plus datapath.
// A word is taken only once the previous one is through: accept, 32 rounds at
//   one round per cycle in the shared round unit, then a load of the result
//   register, which waits while a held result is stalled.
// Reset (i_rst_n low, synchronous) loads register defaults and clears the chain,
//   then a key expansion runs before the first word is taken.
// A key register write starts the same expansion.
`timescale 1ns / 1ps
module sm4_block_cipher_ecb_cbc (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input words
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  sm4_pkg::t_in_word             i_in_word,
    // result words
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output sm4_pkg::t_out_word            o_out_word,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sm4_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                   i_cfg_data
);

    // Commands flow controller -> datapath; the datapath reports the
    // direction bit back so the controller can walk the round keys in
    // forward or reverse order.
    sm4_pkg::t_cmd cmd;
    sm4_pkg::t_sts sts;

    // Controller: owns the state machine, the round counter and the
    // result-valid flag. It takes new words and config writes only when
    // idle; a held result does not block the next word, since the
    // result register is separate from the working state.
    sm4_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: config registers, 32-entry round-key memory, one round
    // unit shared by key expansion and encryption/decryption, the CBC
    // chain value and the result register.
    sm4_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .o_out_word  (o_out_word),
        .o_sts       (sts)
    );

endmodule

[design/sm4_chk.sv]
// SM4 port checker and its bind to the top level.
`timescale 1ns / 1ps
module sm4_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input sm4_pkg::t_out_word            o_out_word,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [sm4_pkg::CFG_IDX_W-1:0] i_cfg_index
);

    logic in_acc;
    logic cfg_acc;
    logic key_acc;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    assign key_acc = cfg_acc && ((i_cfg_index == sm4_pkg::REG_KEY_HIGH) ||
                                 (i_cfg_index == sm4_pkg::REG_KEY_LOW));

    // Held result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // One word in flight at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("second word taken while busy");

    // A result never appears right after acceptance.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(o_out_valid))
        else $error("result word appeared too early");

    // Key write starts expansion: block goes busy.
    a_key_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_acc |=> o_in_stall && !o_cfg_ready)
        else $error("key write did not start key expansion");

    // Config write and word accept never coincide.
    a_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_acc && cfg_acc))
        else $error("config write and input word in same cycle");

endmodule

bind sm4_block_cipher_ecb_cbc sm4_chk u_sm4_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index)
);

[test/tb_sm4_block_cipher_ecb_cbc.sv]
// Self-checking testbench for the SM4 ECB/CBC cipher: result predictor, scoreboard, stimulus.
`timescale 1ns / 1ps
package tb_sm4_ref_pkg;
    import sm4_pkg::*;

    // S-box, entry 0 leftmost
    localparam logic [0:255][7:0] SUB_LUT = {
        256'hd690e9fecce13db716b614c228fb2c05_2b679a762abe04c3aa44132649860699,
        256'h9c4250f491ef987a33540b43edcfac62_e4b31ca9c908e89580df94fa758f3fa6,
        256'h4707a7fcf37317ba83593c19e6854fa8_686b81b27164da8bf8eb0f4b70569d35,
        256'h1e240e5e6358d1a225227c3b01217887_d40046579fd327524c3602e7a0c4c89e,
        256'heabf8ad240c738b5a3f7f2cef96115a1_e0ae5da49b341a55ad933230f58cb1e3,
        256'h1df6e22e8266ca60c02923ab0d534e6f_d5db3745defd8e2f03ff6a726d6c5b51,
        256'h8d1baf92bbddbc7f11d95c411f105ad8_0ac13188a5cd7bbd2d74d012b8e5b4b0,
        256'h8969974a0c96777e65b9f109c56ec684_18f07dec3adc4d2079ee5f3ed7cb3948
    };

    localparam logic [31:0] SYS_PARAM [4] = '{32'ha3b1bac6, 32'h56aa3350,
                                              32'h677d9197, 32'hb27022dc};

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] x);
        return {SUB_LUT[x[31:24]], SUB_LUT[x[23:16]], SUB_LUT[x[15:8]], SUB_LUT[x[7:0]]};
    endfunction

    class sm4_result_board;
        logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
        logic        decrypt, cbc;
        logic [63:0] chain_hi, chain_lo;
        logic [31:0] rkey [32];
        t_out_word   expected_q [$];
        int unsigned mismatches, checked, blocks;
        int unsigned mode_blocks [4];

        function new();
            restore_reset();
        endfunction

        function void restore_reset();
            key_hi   = '0;
            key_lo   = '0;
            iv_hi    = '0;
            iv_lo    = 64'h0102030405060708;
            decrypt  = 1'b0;
            cbc      = 1'b0;
            chain_hi = '0;
            chain_lo = '0;
            expand_keys();
        endfunction

        function void expand_keys();
            logic [31:0] k [4];
            logic [31:0] ck;
            logic [31:0] b;
            k[0] = key_hi[63:32] ^ SYS_PARAM[0];
            k[1] = key_hi[31:0]  ^ SYS_PARAM[1];
            k[2] = key_lo[63:32] ^ SYS_PARAM[2];
            k[3] = key_lo[31:0]  ^ SYS_PARAM[3];
            for (int i = 0; i < 32; i++) begin
                ck = '0;
                for (int j = 0; j < 4; j++) begin
                    ck = {ck[23:0], 8'((4 * i + j) * 7)};
                end
                b = sub_word(k[1] ^ k[2] ^ k[3] ^ ck);
                b = k[0] ^ b ^ rotl(b, 13) ^ rotl(b, 23);
                k[0] = k[1];
                k[1] = k[2];
                k[2] = k[3];
                k[3] = b;
                rkey[i] = b;
            end
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
            case (idx)
                REG_KEY_HIGH: begin
                    key_hi = data;
                    expand_keys();
                end
                REG_KEY_LOW: begin
                    key_lo = data;
                    expand_keys();
                end
                REG_IV_HIGH:   iv_hi   = data;
                REG_IV_LOW:    iv_lo   = data;
                REG_DIRECTION: decrypt = data[0];
                REG_CHAINING:  cbc     = data[0];
                default: ;
            endcase
        endfunction

        function t_out_word crypt(input logic [63:0] hi, input logic [63:0] lo,
                                  input logic dec);
            logic [31:0] x [4];
            logic [31:0] b;
            t_out_word   r;
            x[0] = hi[63:32];
            x[1] = hi[31:0];
            x[2] = lo[63:32];
            x[3] = lo[31:0];
            for (int i = 0; i < 32; i++) begin
                b = sub_word(x[1] ^ x[2] ^ x[3] ^ rkey[dec ? 31 - i : i]);
                b = x[0] ^ b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
                x[0] = x[1];
                x[1] = x[2];
                x[2] = x[3];
                x[3] = b;
            end
            r.result_high = {x[3], x[2]};
            r.result_low  = {x[1], x[0]};
            return r;
        endfunction

        // Predict the result of one accepted input word and queue it.
        function void note_block(input t_in_word w);
            t_out_word r;
            if (w.first_block) begin
                chain_hi = iv_hi;
                chain_lo = iv_lo;
            end
            if (!cbc) begin
                r = crypt(w.block_high, w.block_low, decrypt);
            end else if (!decrypt) begin
                r = crypt(w.block_high ^ chain_hi, w.block_low ^ chain_lo, 1'b0);
                chain_hi = r.result_high;
                chain_lo = r.result_low;
            end else begin
                r = crypt(w.block_high, w.block_low, 1'b1);
                r.result_high ^= chain_hi;
                r.result_low  ^= chain_lo;
                chain_hi = w.block_high;
                chain_lo = w.block_low;
            end
            expected_q.push_back(r);
            blocks++;
            mode_blocks[{cbc, decrypt}]++;
        endfunction

        function void check_result(input t_out_word got);
            t_out_word want;
            checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%0t: result word %h with none outstanding", $time, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.result_high !== want.result_high) begin
                mismatches++;
                $display("%0t: result_high expected %h, got %h",
                         $time, want.result_high, got.result_high);
            end
            if (got.result_low !== want.result_low) begin
                mismatches++;
                $display("%0t: result_low expected %h, got %h",
                         $time, want.result_low, got.result_low);
            end
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction
    endclass
endpackage

module tb_sm4_block_cipher_ecb_cbc;
    import sm4_pkg::*;
    import tb_sm4_ref_pkg::*;

    // indexes past the register list; the block must ignore them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE0 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE1 = 3'd7;

    localparam int unsigned BLOCK_TARGET = 1420;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned CALM_PHASE   = 12;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_word             i_in_word   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_word            o_out_word;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]          i_cfg_data  = '0;

    // percentage of cycles in which each side idles; zero for the calm stretch
    int unsigned     idle_pct   = 33;
    int unsigned     cfg_writes = 0;
    sm4_result_board board;

    sm4_block_cipher_ecb_cbc u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Result side: compare every accepted word, then pick the stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_result(o_out_word);
        end
        i_out_stall <= i_rst_n && ($urandom_range(99) < idle_pct);
    end

    // Mix extremes, single set or cleared bits and plain random values.
    function automatic logic [63:0] pick64();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(63);
            3:       return ~(64'd1 << $urandom_range(63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Write one register; hold valid high so back-to-back writes need no gap.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
        cfg_writes++;
    endtask

    // Present one input word, possibly after an idle gap, and note it once taken.
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                              input logic fb);
        t_in_word w;
        w.block_high  = hi;
        w.block_low   = lo;
        w.first_block = fb;
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        board.note_block(w);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.outstanding() != 0);
    endtask

    initial begin
        t_out_word   kat;
        logic [63:0] v;
        logic        fb;
        int unsigned run_len;
        int unsigned msg_left;
        int unsigned phase;

        board = new();

        // Sanity-check the predictor against the published SM4 test vector.
        board.write_reg(REG_KEY_HIGH, 64'h0123456789abcdef);
        board.write_reg(REG_KEY_LOW,  64'hfedcba9876543210);
        kat = board.crypt(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
        if (kat !== {64'h681edf34d206965e, 64'h86b3e94f536e4246}) begin
            board.mismatches++;
            $display("%0t: predictor known answer expected %h, got %h", $time,
                     {64'h681edf34d206965e, 64'h86b3e94f536e4246}, kat);
        end
        board.restore_reset();

        // Hold reset, then release it; the block then expands the zero key on its own.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Round keys straight from reset: zero key, ECB encrypt.
        send_block('0, '0, 1'b0);
        send_block('1, '1, 1'b0);

        // CBC with no first block yet: chain starts from zero.
        wait_drained();
        cfg_write(REG_CHAINING, 64'd1);
        i_cfg_valid <= 1'b0;
        send_block(pick64(), pick64(), 1'b0);
        send_block('1, '0, 1'b0);
        // first block picks up the reset IV
        send_block(pick64(), pick64(), 1'b1);
        send_block(pick64(), pick64(), 1'b0);

        // Standard key, ECB through wide register values whose low bit is clear.
        wait_drained();
        cfg_write(REG_KEY_HIGH, 64'h0123456789abcdef);
        cfg_write(REG_KEY_LOW, 64'hfedcba9876543210);
        cfg_write(REG_IV_HIGH, pick64());
        cfg_write(REG_IV_LOW, pick64());
        cfg_write(REG_CHAINING, 64'hffff_ffff_ffff_fffe);
        cfg_write(REG_DIRECTION, 64'h2);
        i_cfg_valid <= 1'b0;
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
        // first block in ECB still reloads the chain from the IV
        send_block(pick64(), pick64(), 1'b1);

        // CBC encrypt continuing from the chain loaded during ECB.
        wait_drained();
        cfg_write(REG_CHAINING, 64'h8000_0000_0000_0001);
        i_cfg_valid <= 1'b0;
        send_block(pick64(), pick64(), 1'b0);

        // CBC decrypt.
        wait_drained();
        cfg_write(REG_DIRECTION, '1);
        i_cfg_valid <= 1'b0;
        send_block(pick64(), pick64(), 1'b1);
        send_block(pick64(), pick64(), 1'b0);
        send_block(pick64(), pick64(), 1'b0);

        // ECB decrypt of the known ciphertext.
        wait_drained();
        cfg_write(REG_CHAINING, '0);
        i_cfg_valid <= 1'b0;
        send_block(64'h681edf34d206965e, 64'h86b3e94f536e4246, 1'b0);
        send_block('1, '1, 1'b1);

        // All-ones key and IV, plus writes past the register list that must do nothing.
        wait_drained();
        cfg_write(REG_SPARE0, '1);
        cfg_write(REG_SPARE1, '1);
        cfg_write(REG_KEY_HIGH, '1);
        cfg_write(REG_KEY_LOW, '1);
        cfg_write(REG_IV_HIGH, '1);
        cfg_write(REG_IV_LOW, '1);
        cfg_write(REG_CHAINING, 64'd1);
        cfg_write(REG_DIRECTION, '0);
        i_cfg_valid <= 1'b0;
        send_block('1, '1, 1'b1);
        send_block('0, '0, 1'b0);
        send_block('1, '0, 1'b0);
        wait_drained();
        cfg_write(REG_DIRECTION, 64'd1);
        i_cfg_valid <= 1'b0;
        send_block('1, '1, 1'b1);
        send_block('0, '1, 1'b0);

        // Random phases: new settings between phases, then messages of a few blocks
        // that open with a first block, with the odd flag flipped at random.
        msg_left = 0;
        phase    = 0;
        while (board.blocks < BLOCK_TARGET) begin
            wait_drained();
            if ($urandom_range(3) == 0) cfg_write(REG_KEY_HIGH, pick64());
            if ($urandom_range(3) == 0) cfg_write(REG_KEY_LOW, pick64());
            if ($urandom_range(1) == 0) cfg_write(REG_IV_HIGH, pick64());
            if ($urandom_range(1) == 0) cfg_write(REG_IV_LOW, pick64());
            if ($urandom_range(1) == 0) cfg_write(REG_DIRECTION, pick64());
            if ($urandom_range(1) == 0) begin
                // lean toward CBC, where the chain state lives
                v    = pick64();
                v[0] = ($urandom_range(3) != 0);
                cfg_write(REG_CHAINING, v);
            end
            if ($urandom_range(15) == 0) begin
                cfg_write($urandom_range(1) ? REG_SPARE0 : REG_SPARE1, pick64());
            end
            i_cfg_valid <= 1'b0;

            // One long phase runs with neither side idling.
            idle_pct = (phase == CALM_PHASE) ? 0 : 33;
            run_len  = (phase == CALM_PHASE) ? 150 : $urandom_range(1, 40);
            repeat (run_len) begin
                if (msg_left == 0) begin
                    msg_left = $urandom_range(1, 8);
                    fb       = 1'b1;
                end else begin
                    fb = 1'b0;
                end
                msg_left--;
                if ($urandom_range(9) == 0) fb = $urandom_range(1);
                send_block(pick64(), pick64(), fb);
            end
            phase++;
        end

        // Drain, then give a stray extra word time to show up.
        idle_pct = 33;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d blocks in %0d random phases: ECB enc %0d, ECB dec %0d, CBC enc %0d, CBC dec %0d",
                 board.blocks, phase, board.mode_blocks[0], board.mode_blocks[1],
                 board.mode_blocks[2], board.mode_blocks[3]);
        $display("%0d results compared, %0d register writes, %0d mismatches",
                 board.checked, cfg_writes, board.mismatches);
        if (board.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Stop a hung run; a correct one ends far sooner.
    initial begin
        #6_000_000;
        $display("FAIL");
        $finish;
    end
endmodule

[filelist.f]
design/sm4_pkg.sv
design/sm4_ctrl.sv
design/sm4_dpath.sv
design/sm4_block_cipher_ecb_cbc.sv
design/sm4_chk.sv
test/tb_sm4_block_cipher_ecb_cbc.sv
